FILE: sv/itrd_pkg.sv
`default_nettype none

package itrd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int STEP_BITS   = 8;
  localparam int DIV_CYCLES  = VALUE_WIDTH / STEP_BITS;
  localparam int STEP_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int DIGIT_CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DIGIT_IDX_W = $clog2(VALUE_WIDTH);

  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int SYMBOL_W  = 8;
  localparam int ALPHA_W   = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [RADIX_W-1:0]  MIN_RADIX   = 5'd2;
  localparam logic [RADIX_W-1:0]  MAX_RADIX   = 5'd16;
  localparam logic [RADIX_W-1:0]  RADIX_RESET = 5'd10;
  localparam logic [SYMBOL_W-1:0] MINUS_SIGN  = 8'h2D;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIX        = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  function automatic logic [SYMBOL_W-1:0] symbol_of(
    input logic [DIGIT_W-1:0] digit,
    input logic [ALPHA_W-1:0] lo,
    input logic [ALPHA_W-1:0] hi
  );
    logic [2*ALPHA_W-1:0] alphabet;
    alphabet = {hi, lo};
    return alphabet[{digit, 3'b000} +: SYMBOL_W];
  endfunction

endpackage

`default_nettype wire

FILE: sv/integer_to_radix_digits_unit.sv
// Converts one signed value into its characters, most significant first.
// The divider works out eight quotient bits per cycle for each digit, and the
// first character is loaded once every digit of the value has been found.
// A new value is taken only after the last character of the previous one is
// loaded, so output stalls also hold the input.
// Reset is synchronous: radix returns to 10, both alphabets to zero,
// and the digit store needs no clearing.
`default_nettype none

module integer_to_radix_digits_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [itrd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [itrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic signed [itrd_pkg::VALUE_WIDTH-1:0] value,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [itrd_pkg::SYMBOL_W-1:0]       symbol,
  output      logic                                is_last
);

  itrd_pkg::state_t state;

  logic [itrd_pkg::RADIX_W-1:0]     radix;
  logic [itrd_pkg::ALPHA_W-1:0]     symbols_low;
  logic [itrd_pkg::ALPHA_W-1:0]     symbols_high;
  logic [itrd_pkg::RADIX_W-1:0]     radix_eff;

  logic [itrd_pkg::VALUE_WIDTH-1:0] remaining_magnitude;
  logic [itrd_pkg::DIGIT_W-1:0]     remainder;
  logic [itrd_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic [itrd_pkg::DIGIT_W-1:0]     digit_store [itrd_pkg::VALUE_WIDTH];
  logic [itrd_pkg::DIGIT_CNT_W-1:0] digit_count;
  logic [itrd_pkg::DIGIT_CNT_W-1:0] count_m1;
  logic                             negative_flag;

  logic [itrd_pkg::VALUE_WIDTH-1:0] magnitude_next;
  logic [itrd_pkg::DIGIT_W-1:0]     remainder_next;
  logic [itrd_pkg::RADIX_W-1:0]     trial;
  logic                             qbit;
  logic                             in_take;
  logic                             out_load;
  logic                             last_step;

  always_comb begin
    if (radix < itrd_pkg::MIN_RADIX) begin
      radix_eff = itrd_pkg::MIN_RADIX;
    end else if (radix > itrd_pkg::MAX_RADIX) begin
      radix_eff = itrd_pkg::MAX_RADIX;
    end else begin
      radix_eff = radix;
    end
  end

  // Restoring long division by the radix, a slice of quotient bits per cycle.
  always_comb begin
    magnitude_next = remaining_magnitude;
    remainder_next = remainder;
    trial          = '0;
    qbit           = 1'b0;
    for (int b = 0; b < itrd_pkg::STEP_BITS; b++) begin
      trial = {remainder_next, magnitude_next[itrd_pkg::VALUE_WIDTH-1]};
      if (trial >= radix_eff) begin
        trial = trial - radix_eff;
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      remainder_next = trial[itrd_pkg::DIGIT_W-1:0];
      magnitude_next = {magnitude_next[itrd_pkg::VALUE_WIDTH-2:0], qbit};
    end
  end

  assign in_stall  = (state != itrd_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == itrd_pkg::ST_EMIT) && (!out_valid || !out_stall);
  assign last_step = (step_cnt == itrd_pkg::STEP_CNT_W'(itrd_pkg::DIV_CYCLES - 1));
  assign count_m1  = digit_count - itrd_pkg::DIGIT_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= itrd_pkg::RADIX_RESET;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        itrd_pkg::CFG_RADIX:        radix        <= cfg_data[itrd_pkg::RADIX_W-1:0];
        itrd_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        itrd_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == itrd_pkg::ST_DIVIDE) && last_step) begin
      digit_store[digit_count[itrd_pkg::DIGIT_IDX_W-1:0]] <= remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (negative_flag) begin
        symbol  <= itrd_pkg::MINUS_SIGN;
        is_last <= 1'b0;
      end else begin
        symbol  <= itrd_pkg::symbol_of(digit_store[count_m1[itrd_pkg::DIGIT_IDX_W-1:0]],
                                       symbols_low, symbols_high);
        is_last <= (digit_count == itrd_pkg::DIGIT_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= itrd_pkg::ST_IDLE;
      remaining_magnitude <= '0;
      remainder           <= '0;
      step_cnt            <= '0;
      digit_count         <= '0;
      negative_flag       <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        itrd_pkg::ST_IDLE: begin
          if (in_take) begin
            negative_flag       <= value[itrd_pkg::VALUE_WIDTH-1];
            remaining_magnitude <= value[itrd_pkg::VALUE_WIDTH-1] ?
                                   (~value + itrd_pkg::VALUE_WIDTH'(1)) : value;
            remainder           <= '0;
            step_cnt            <= '0;
            digit_count         <= '0;
            state               <= itrd_pkg::ST_DIVIDE;
          end
        end
        itrd_pkg::ST_DIVIDE: begin
          remaining_magnitude <= magnitude_next;
          if (last_step) begin
            step_cnt    <= '0;
            remainder   <= '0;
            digit_count <= digit_count + itrd_pkg::DIGIT_CNT_W'(1);
            if (magnitude_next == '0) begin
              state <= itrd_pkg::ST_EMIT;
            end
          end else begin
            step_cnt  <= step_cnt + itrd_pkg::STEP_CNT_W'(1);
            remainder <= remainder_next;
          end
        end
        itrd_pkg::ST_EMIT: begin
          if (out_load) begin
            if (negative_flag) begin
              negative_flag <= 1'b0;
            end else begin
              digit_count <= count_m1;
              if (digit_count == itrd_pkg::DIGIT_CNT_W'(1)) begin
                state <= itrd_pkg::ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= itrd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/itrd_checker.sv
`default_nettype none

module itrd_checker (
  input wire logic                                    clk,
  input wire logic                                    rst,
  input wire logic                                    in_valid,
  input wire logic                                    in_stall,
  input wire logic                                    out_valid,
  input wire logic                                    out_stall,
  input wire logic [itrd_pkg::SYMBOL_W-1:0]           symbol,
  input wire logic                                    is_last
);

  // A stalled character must stay in place until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(is_last))
    else $error("output transaction changed while stalled");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

  // After a value is taken the unit is busy converting it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a conversion is starting");

  // Until the last character of a value is loaded, the input stays stalled.
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> in_stall)
    else $error("input ready before the last character");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (.*);

`default_nettype wire

FILE: tb/sv/integer_to_radix_digits_unit_test.sv
module integer_to_radix_digits_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT       = 3000;
  localparam int SETTLE_CYCLES        = 200;
  localparam int RECEIVER_HOLD_CYCLES = 400;
  localparam int VALUES_PER_SETTING   = 19;

  localparam logic [itrd_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [itrd_pkg::ALPHA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [itrd_pkg::ALPHA_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;
  localparam logic [itrd_pkg::VALUE_WIDTH-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
  localparam logic [itrd_pkg::VALUE_WIDTH-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [itrd_pkg::VALUE_WIDTH-1:0] MINUS_ONE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [itrd_pkg::SYMBOL_W-1:0] symbol;
    logic                          is_last;
  } text_char_t;

  logic                                    clk       = 1'b0;
  logic                                    rst       = 1'b1;
  logic                                    cfg_write = 1'b0;
  logic [itrd_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [itrd_pkg::CFG_DATA_W-1:0]         cfg_data  = '0;
  logic                                    in_valid  = 1'b0;
  logic signed [itrd_pkg::VALUE_WIDTH-1:0] value     = '0;
  logic                                    out_stall = 1'b0;
  logic                                    in_stall;
  logic                                    out_valid;
  logic [itrd_pkg::SYMBOL_W-1:0]           symbol;
  logic                                    is_last;

  logic [itrd_pkg::RADIX_W-1:0] radix_setting        = itrd_pkg::RADIX_RESET;
  logic [itrd_pkg::ALPHA_W-1:0] symbols_low_setting  = '0;
  logic [itrd_pkg::ALPHA_W-1:0] symbols_high_setting = '0;

  text_char_t expected_chars[$];

  int error_count       = 0;
  int values_converted  = 0;
  int chars_checked     = 0;
  int radix_settings    = 0;
  int quiet_cycles      = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  logic hold_active     = 1'b0;
  event start_hold;

  integer_to_radix_digits_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .is_last   (is_last)
  );

  always #2 clk = ~clk;

  function automatic logic [itrd_pkg::SYMBOL_W-1:0] alphabet_symbol(
    input logic [itrd_pkg::DIGIT_W-1:0] digit
  );
    if (digit[3]) begin
      return symbols_high_setting[digit[2:0] * 8 +: itrd_pkg::SYMBOL_W];
    end
    return symbols_low_setting[digit[2:0] * 8 +: itrd_pkg::SYMBOL_W];
  endfunction

  function automatic int unsigned effective_base();
    if (radix_setting < itrd_pkg::MIN_RADIX) begin
      return itrd_pkg::MIN_RADIX;
    end
    if (radix_setting > itrd_pkg::MAX_RADIX) begin
      return itrd_pkg::MAX_RADIX;
    end
    return radix_setting;
  endfunction

  function automatic void predict_characters(input logic [itrd_pkg::VALUE_WIDTH-1:0] raw);
    logic                             negative;
    logic [itrd_pkg::VALUE_WIDTH-1:0] magnitude;
    logic [itrd_pkg::DIGIT_W-1:0]     digits[itrd_pkg::VALUE_WIDTH];
    int unsigned                      base;
    int                               count;
    base      = effective_base();
    negative  = raw[itrd_pkg::VALUE_WIDTH-1];
    magnitude = negative ? (~raw + 1'b1) : raw;
    count     = 0;
    if (magnitude == 0) begin
      expected_chars.push_back('{alphabet_symbol(4'd0), 1'b1});
      return;
    end
    while (magnitude != 0) begin
      digits[count] = itrd_pkg::DIGIT_W'(magnitude % base);
      magnitude     = magnitude / base;
      count++;
    end
    if (negative) begin
      expected_chars.push_back('{itrd_pkg::MINUS_SIGN, 1'b0});
    end
    for (int i = count - 1; i >= 0; i--) begin
      expected_chars.push_back('{alphabet_symbol(digits[i]), i == 0});
    end
  endfunction

  function automatic logic [itrd_pkg::VALUE_WIDTH-1:0] random_value();
    logic [itrd_pkg::VALUE_WIDTH-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(300);
      6, 7: v = 32'd0 - 32'($urandom_range(1, 300));
      8: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 32'd1;
          2: v = MINUS_ONE;
          3: v = MOST_POSITIVE;
          default: v = MOST_NEGATIVE;
        endcase
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
  endtask

  task automatic write_register(input logic [itrd_pkg::CFG_INDEX_W-1:0] index,
                                input logic [itrd_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (index)
      itrd_pkg::CFG_RADIX: begin
        radix_setting = data[itrd_pkg::RADIX_W-1:0];
        radix_settings++;
      end
      itrd_pkg::CFG_SYMBOLS_LOW: symbols_low_setting = data;
      itrd_pkg::CFG_SYMBOLS_HIGH: symbols_high_setting = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_radix(input logic [itrd_pkg::RADIX_W-1:0] base);
    logic [itrd_pkg::CFG_DATA_W-1:0] data;
    data                          = {$urandom, $urandom};
    data[itrd_pkg::RADIX_W-1:0]   = base;
    write_register(itrd_pkg::CFG_RADIX, data);
  endtask

  task automatic send_value(input logic [itrd_pkg::VALUE_WIDTH-1:0] v);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_characters(v);
    values_converted++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic load_random_setting();
    logic [itrd_pkg::RADIX_W-1:0] base;
    if ($urandom_range(7) == 0) begin
      base = itrd_pkg::RADIX_W'($urandom_range(31));
    end else begin
      base = itrd_pkg::RADIX_W'($urandom_range(itrd_pkg::MIN_RADIX, itrd_pkg::MAX_RADIX));
    end
    write_radix(base);
    write_register(itrd_pkg::CFG_SYMBOLS_LOW, {$urandom, $urandom});
    write_register(itrd_pkg::CFG_SYMBOLS_HIGH, {$urandom, $urandom});
  endtask

  task automatic test_reset_alphabet();
    send_value('0);
    send_value(32'd1);
    send_value(MINUS_ONE);
    send_value(MOST_POSITIVE);
    send_value(MOST_NEGATIVE);
    pause_until_drained();
  endtask

  task automatic test_directed_conversions();
    logic [itrd_pkg::RADIX_W-1:0] bases[3];
    bases = '{itrd_pkg::MIN_RADIX, itrd_pkg::RADIX_RESET, itrd_pkg::MAX_RADIX};
    write_register(itrd_pkg::CFG_SYMBOLS_LOW, HEX_LOW);
    write_register(itrd_pkg::CFG_SYMBOLS_HIGH, HEX_HIGH);
    foreach (bases[i]) begin
      write_radix(bases[i]);
      send_value('0);
      send_value(32'd1);
      send_value(MINUS_ONE);
      send_value(MOST_POSITIVE);
      send_value(MOST_NEGATIVE);
      pause_until_drained();
    end
  endtask

  task automatic test_radix_saturation();
    logic [itrd_pkg::RADIX_W-1:0] bases[4];
    bases = '{5'd0, 5'd1, 5'd17, 5'd31};
    foreach (bases[i]) begin
      write_radix(bases[i]);
      send_value(random_value());
      pause_until_drained();
    end
  endtask

  task automatic test_unmapped_index();
    write_radix(5'd7);
    write_register(CFG_UNMAPPED, {$urandom, $urandom});
    send_value(MOST_NEGATIVE);
    pause_until_drained();
  endtask

  task automatic test_random_conversions(input int send_pct, input int recv_pct,
                                         input int count);
    set_idling(send_pct, recv_pct);
    for (int i = 0; i < count; i++) begin
      if (i % VALUES_PER_SETTING == 0) begin
        pause_until_drained();
        load_random_setting();
      end
      send_value(random_value());
    end
    pause_until_drained();
  endtask

  task automatic test_output_backpressure();
    set_idling(0, 0);
    write_radix(itrd_pkg::MIN_RADIX);
    -> start_hold;
    repeat (6) begin
      send_value(MOST_NEGATIVE | $urandom);
    end
    pause_until_drained();
  endtask

  always @(posedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (RECEIVER_HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_characters
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character %h arrived with no value pending", symbol));
      end else begin
        want = expected_chars.pop_front();
        if (symbol !== want.symbol) begin
          report_mismatch($sformatf("symbol %h, expected %h", symbol, want.symbol));
        end
        if (is_last !== want.is_last) begin
          report_mismatch($sformatf("is_last %b, expected %b", is_last, want.is_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d characters still pending.", expected_chars.size());
      $display("[integer_to_radix_digits_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_idling(33, 84);
    test_reset_alphabet();
    test_directed_conversions();
    test_radix_saturation();
    test_unmapped_index();
    test_random_conversions(33, 84, 46);
    test_random_conversions(84, 33, 46);
    test_random_conversions(0, 0, 46);
    test_output_backpressure();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    end
    $display("Converted %0d values into %0d characters under %0d radix settings.",
             values_converted, chars_checked, radix_settings);
    $display("Covered zero, sign extremes, radix saturation, random alphabets and a long hold.");
    if (error_count == 0) begin
      $display("[integer_to_radix_digits_unit] OK");
    end else begin
      $display("[integer_to_radix_digits_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/itrd_pkg.sv
sv/integer_to_radix_digits_unit.sv
sv/itrd_checker.sv
tb/sv/integer_to_radix_digits_unit_test.sv
